>>> hw/rtl/ssbm_pkg.sv
// shared types and helpers for the magnitude sorter
`timescale 1ns / 1ps

package ssbm_pkg;

  localparam int unsigned DataW = 32;

  // control broadcast from the top level to every cell
  typedef struct packed {
    logic             insert;
    logic             drain;
    logic [DataW-1:0] value;
    logic [DataW-1:0] mag;
  } cell_ctrl_t;

  // unsigned absolute value, the most negative code maps to 2^31
  function automatic logic [DataW-1:0] magnitude(input logic [DataW-1:0] v);
    logic [DataW-1:0] m;
    m = v[DataW-1] ? (~v + {{(DataW-1){1'b0}}, 1'b1}) : v;
    return m;
  endfunction

endpackage

>>> hw/rtl/stable_sort_by_magnitude.sv
// top level of the stable magnitude sorter: cell chain, fill count and drain control
//
//  channel   direction  signals                                   transfer when
//  command   in         start, busy, value_i, last_item_i        start && !busy
//  result    out        valid_o, sorted_value_o, last_result_o,  valid_o (one cycle)
//                       overflow_o
//
// one item is taken per cycle while not busy; the broadcast compare in every
// cell places the newcomer directly in its cell's register when it is taken.
// after an item flagged last, busy rises and the chain shifts towards cell 0
// once a cycle, so the run comes out at one result per cycle, one result for
// each stored item.
// reset clears valid bits, fill count, drop flag and drain state; stored
// values need no reset.
// the receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module stable_sort_by_magnitude #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [ssbm_pkg::DataW-1:0] value_i,
  input  logic                       last_item_i,
  output logic                       valid_o,
  output logic [ssbm_pkg::DataW-1:0] sorted_value_o,
  output logic                       last_result_o,
  output logic                       overflow_o
);

  localparam int unsigned FillW = $clog2(MAX_ITEMS + 1);
  localparam logic [FillW-1:0] FillMax = FillW'(MAX_ITEMS);
  localparam logic [FillW-1:0] FillOne = FillW'(1);

  logic                  accept;
  logic                  full;
  logic [FillW-1:0]      fill_q, fill_d;
  logic                  dropped_q, dropped_d;
  logic                  drain_q, drain_d;
  ssbm_pkg::cell_ctrl_t  ctrl;

  logic [MAX_ITEMS-1:0]                      cell_keep;
  logic [MAX_ITEMS-1:0]                      cell_valid;
  logic [MAX_ITEMS-1:0][ssbm_pkg::DataW-1:0] cell_value;

  assign accept = start && !busy;
  assign full   = (fill_q == FillMax);

  // broadcast to the chain; a full store drops the item
  assign ctrl.insert = accept && !full;
  assign ctrl.drain  = drain_q;
  assign ctrl.value  = value_i;
  assign ctrl.mag    = ssbm_pkg::magnitude(value_i);

  // the chain of cells, cell 0 holds the smallest magnitude
  for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
    logic                       prev_keep;
    logic [ssbm_pkg::DataW-1:0] prev_value;
    logic                       prev_valid;
    logic [ssbm_pkg::DataW-1:0] next_value;
    logic                       next_valid;

    if (k == 0) begin : g_head
      // nothing ahead of the head: it takes the newcomer when it does not keep
      assign prev_keep  = 1'b1;
      assign prev_value = '0;
      assign prev_valid = 1'b0;
    end else begin : g_body
      assign prev_keep  = cell_keep[k-1];
      assign prev_value = cell_value[k-1];
      assign prev_valid = cell_valid[k-1];
    end

    if (k == MAX_ITEMS - 1) begin : g_tail
      // empty slot shifts in at the tail while draining
      assign next_value = '0;
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_value = cell_value[k+1];
      assign next_valid = cell_valid[k+1];
    end

    ssbm_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_keep_i  (prev_keep),
      .prev_value_i (prev_value),
      .prev_valid_i (prev_valid),
      .next_value_i (next_value),
      .next_valid_i (next_valid),
      .keep_o       (cell_keep[k]),
      .value_o      (cell_value[k]),
      .valid_o      (cell_valid[k])
    );
  end

  // fill count doubles as the drain countdown
  always_comb begin
    fill_d    = fill_q;
    dropped_d = dropped_q;
    drain_d   = drain_q;
    if (drain_q) begin
      fill_d = fill_q - FillOne;
      if (fill_q == FillOne) begin
        drain_d   = 1'b0;
        dropped_d = 1'b0;
      end
    end else if (accept) begin
      if (full) begin
        dropped_d = 1'b1;
      end else begin
        fill_d = fill_q + FillOne;
      end
      // a run always holds at least one item here, so draining is safe
      if (last_item_i) begin
        drain_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      dropped_q <= 1'b0;
      drain_q   <= 1'b0;
    end else begin
      fill_q    <= fill_d;
      dropped_q <= dropped_d;
      drain_q   <= drain_d;
    end
  end

  assign busy           = drain_q;
  assign valid_o        = drain_q;
  assign sorted_value_o = cell_value[0];
  assign last_result_o  = drain_q && (fill_q == FillOne);
  assign overflow_o     = drain_q && dropped_q;

  // the final result of a run ends the drain
  a_last_ends_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_result_o |=> !valid_o)
    else $error("result strobe continued after final result");

  // an accepted last item starts the drain in the next cycle
  a_last_starts_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_item_i) |=> valid_o)
    else $error("no result after last item");

  // every result shown comes from an occupied head cell
  a_head_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> cell_valid[0])
    else $error("result taken from an empty cell");

  // outside a drain the fill count matches the chain occupancy at the head
  a_fill_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !drain_q |-> ((fill_q == '0) == !cell_valid[0]))
    else $error("fill count and chain occupancy disagree");

endmodule

>>> hw/rtl/ssbm_cell.sv
// one cell of the insertion chain: holds one value and its valid bit
`timescale 1ns / 1ps

module ssbm_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ssbm_pkg::cell_ctrl_t      ctrl_i,
  input  logic                      prev_keep_i,
  input  logic [ssbm_pkg::DataW-1:0] prev_value_i,
  input  logic                      prev_valid_i,
  input  logic [ssbm_pkg::DataW-1:0] next_value_i,
  input  logic                      next_valid_i,
  output logic                      keep_o,
  output logic [ssbm_pkg::DataW-1:0] value_o,
  output logic                      valid_o
);

  logic [ssbm_pkg::DataW-1:0] value_q, value_d;
  logic                       valid_q, valid_d;

  // equal magnitudes stay ahead of the newcomer, which keeps the order stable
  assign keep_o = valid_q && (ssbm_pkg::magnitude(value_q) <= ctrl_i.mag);

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (ctrl_i.drain) begin
      value_d = next_value_i;
      valid_d = next_valid_i;
    end else if (ctrl_i.insert && !keep_o) begin
      if (prev_keep_i) begin
        value_d = ctrl_i.value;
        valid_d = 1'b1;
      end else begin
        value_d = prev_value_i;
        valid_d = prev_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign valid_o = valid_q;

endmodule

>>> test/tb_stable_sort_by_magnitude.sv
// self-checking testbench for the stable magnitude sorter
`timescale 1ns / 1ps

module tb_stable_sort_by_magnitude;

  localparam int unsigned DataW      = ssbm_pkg::DataW;
  localparam int          MaxItems   = 64;
  localparam int          RandItems  = 250;   // random input transfers, rounded up to a run end
  localparam int          MaxGap     = 18;
  localparam int          DrainTail  = 80;    // a full drain plus margin
  localparam int          CycleLimit = 400000;
  localparam int          ReportMax  = 10;
  localparam int          NumRows    = 17;

  // one sorted result as seen on the result ports
  typedef struct packed {
    logic [DataW-1:0] value;
    logic             last;
    logic             ovf;
  } sort_res_t;

  // directed stimulus row: reps items first, first+step, ..., the final one
  // flagged last when last is set; typed rows carry their single result
  typedef struct packed {
    logic [DataW-1:0] first;
    logic [DataW-1:0] step;
    logic [7:0]       reps;
    logic             last;
    logic             typed;
    sort_res_t        want;
  } stim_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [DataW-1:0] value_i;
  logic             last_item_i;
  logic             valid_o;
  logic [DataW-1:0] sorted_value_o;
  logic             last_result_o;
  logic             overflow_o;

  stable_sort_by_magnitude #(
    .MAX_ITEMS(MaxItems)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .value_i       (value_i),
    .last_item_i   (last_item_i),
    .valid_o       (valid_o),
    .sorted_value_o(sorted_value_o),
    .last_result_o (last_result_o),
    .overflow_o    (overflow_o)
  );

  always #10 clk_i = ~clk_i;

  // predictor state: the sorted run so far, its length and the drop flag
  logic [DataW-1:0] run_store [MaxItems];
  int               run_fill;
  logic             run_dropped;

  sort_res_t sorted_due [$];   // results still to come off the result ports
  sort_res_t drained    [$];   // what the last transfer would emit

  stim_row_t dir_rows [NumRows];

  int items_sent;
  int runs_sent;
  int overflow_runs;
  int results_checked;
  int mismatches;
  int cycles;

  // unsigned magnitude, so the most negative code is the largest
  function automatic logic [DataW-1:0] abs_of(input logic [DataW-1:0] v);
    if (v[DataW-1])
      return {DataW{1'b0}} - v;
    return v;
  endfunction

  // insert one value behind every entry of equal magnitude; on the last item
  // the whole run goes into drained and the predictor starts a fresh run
  task automatic sort_insert(input logic [DataW-1:0] v, input logic lst);
    logic [DataW-1:0] mv;
    int               pos;
    drained.delete();
    if (run_fill < MaxItems) begin
      mv  = abs_of(v);
      pos = run_fill;
      while (pos > 0 && abs_of(run_store[pos-1]) > mv) begin
        run_store[pos] = run_store[pos-1];
        pos--;
      end
      run_store[pos] = v;
      run_fill++;
    end else begin
      // store full: the element is lost, the run is marked
      run_dropped = 1'b1;
    end
    if (lst) begin
      for (int k = 0; k < run_fill; k++)
        drained.push_back('{value: run_store[k], last: (k == run_fill - 1), ovf: run_dropped});
      if (run_dropped)
        overflow_runs++;
      runs_sent++;
      run_fill    = 0;
      run_dropped = 1'b0;
    end
  endtask

  // one input transfer: idle for the given gap, present the item at a falling
  // edge and hold it until a rising edge sees busy low
  task automatic send_item(input logic [DataW-1:0] v, input logic lst, input int gap,
                           input logic typed, input sort_res_t want);
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start       <= 1'b1;
    value_i     <= v;
    last_item_i <= lst;
    do
      @(posedge clk_i);
    while (busy !== 1'b0);
    items_sent++;
    sort_insert(v, lst);
    // a typed row replaces the predicted result by the one written in the table
    if (typed)
      sorted_due.push_back(want);
    else
      foreach (drained[k])
        sorted_due.push_back(drained[k]);
  endtask

  // values weighted towards ties and the ends of the range
  function automatic logic [DataW-1:0] pick_value();
    logic [DataW-1:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: begin
        v = $urandom_range(0, 7);
        if ($urandom_range(0, 1))
          v = {DataW{1'b0}} - v;
      end
      2: case ($urandom_range(0, 5))
        0: v = 32'h0000_0000;
        1: v = 32'h8000_0000;
        2: v = 32'h7FFF_FFFF;
        3: v = 32'h8000_0001;
        4: v = 32'hFFFF_FFFF;
        default: v = 32'h0000_0001;
      endcase
      default: v = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
    endcase
    return v;
  endfunction

  // every result transfer is taken at the rising edge that ends its cycle
  always @(posedge clk_i) begin : check_results
    sort_res_t got;
    sort_res_t want;
    if (rst_ni && valid_o !== 1'b0) begin
      got = '{value: sorted_value_o, last: last_result_o, ovf: overflow_o};
      if (sorted_due.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("unexpected result: value %h last %b overflow %b",
                   got.value, got.last, got.ovf);
      end else begin
        want = sorted_due.pop_front();
        results_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= ReportMax)
            $display("result %0d: expected value %h last %b overflow %b, got %h %b %b",
                     results_checked, want.value, want.last, want.ovf,
                     got.value, got.last, got.ovf);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sorted_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    int        run_len;
    int        rand_items;
    logic      no_idle;
    sort_res_t none;
    logic [DataW-1:0] v;

    rst_ni        = 1'b0;
    start         = 1'b0;
    value_i       = '0;
    last_item_i   = 1'b0;
    items_sent    = 0;
    runs_sent     = 0;
    overflow_runs = 0;
    results_checked = 0;
    mismatches    = 0;
    cycles        = 0;
    run_fill      = 0;
    run_dropped   = 1'b0;
    rand_items    = 0;
    none          = '0;

    //              first          step           reps last typed  expected result
    // single-item runs straight after reset and at the ends of the range
    dir_rows[0]  = '{32'h0000_0000, 32'h0, 8'd1, 1'b1, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}};
    dir_rows[1]  = '{32'h7FFF_FFFF, 32'h0, 8'd1, 1'b1, 1'b1, '{32'h7FFF_FFFF, 1'b1, 1'b0}};
    dir_rows[2]  = '{32'h8000_0000, 32'h0, 8'd1, 1'b1, 1'b1, '{32'h8000_0000, 1'b1, 1'b0}};
    dir_rows[3]  = '{32'hFFFF_FFFF, 32'h0, 8'd1, 1'b1, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0}};
    dir_rows[4]  = '{32'h8000_0001, 32'h0, 8'd1, 1'b1, 1'b1, '{32'h8000_0001, 1'b1, 1'b0}};
    // one run of ties of both signs; -2^31 must come out after +2^31-1
    dir_rows[5]  = '{32'h0000_0005, 32'h0, 8'd1, 1'b0, 1'b0, none};
    dir_rows[6]  = '{32'hFFFF_FFFB, 32'h0, 8'd1, 1'b0, 1'b0, none};
    dir_rows[7]  = '{32'h0000_0003, 32'h0, 8'd1, 1'b0, 1'b0, none};
    dir_rows[8]  = '{32'hFFFF_FFFD, 32'h0, 8'd1, 1'b0, 1'b0, none};
    dir_rows[9]  = '{32'h8000_0000, 32'h0, 8'd1, 1'b0, 1'b0, none};
    dir_rows[10] = '{32'h7FFF_FFFF, 32'h0, 8'd1, 1'b0, 1'b0, none};
    dir_rows[11] = '{32'h8000_0001, 32'h0, 8'd1, 1'b0, 1'b0, none};
    dir_rows[12] = '{32'h0000_0000, 32'h0, 8'd1, 1'b0, 1'b0, none};
    dir_rows[13] = '{32'h0000_0001, 32'h0, 8'd1, 1'b0, 1'b0, none};
    dir_rows[14] = '{32'hFFFF_FFFF, 32'h0, 8'd1, 1'b1, 1'b0, none};
    // store filled exactly, arriving in descending order
    dir_rows[15] = '{32'h0000_0040, 32'hFFFF_FFFF, 8'd64, 1'b1, 1'b0, none};
    // one past capacity: the last item itself is dropped, the run still drains
    dir_rows[16] = '{32'hFFFF_FFE0, 32'h0000_0001, 8'd65, 1'b1, 1'b0, none};

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[r]) begin
      for (int k = 0; k < dir_rows[r].reps; k++) begin
        v = dir_rows[r].first + dir_rows[r].step * k;
        send_item(v, dir_rows[r].last && (k == dir_rows[r].reps - 1),
                  $urandom_range(0, MaxGap), dir_rows[r].typed, dir_rows[r].want);
      end
    end

    // random runs: mostly short, now and then long enough to overflow;
    // some runs go back to back so that drains meet fresh transfers at once
    while (rand_items < RandItems) begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 80) : $urandom_range(1, 12);
      no_idle = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < run_len; k++) begin
        send_item(pick_value(), k == run_len - 1,
                  no_idle ? 0 : $urandom_range(0, MaxGap), 1'b0, none);
        rand_items++;
      end
    end

    @(negedge clk_i);
    start <= 1'b0;

    // let the final drain finish, then watch for stray results
    while (sorted_due.size() != 0)
      @(posedge clk_i);
    repeat (DrainTail) @(posedge clk_i);

    $display("sent %0d items in %0d runs (%0d with dropped items), checked %0d sorted results",
             items_sent, runs_sent, overflow_runs, results_checked);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
